// ----- sv/cca_pkg.sv -----
// Package for the calendar clock advance block.
// Holds the controller state type, command and status structs, register
// indexes, field widths and the month length helper. No dependencies.
`default_nettype none

package cca_pkg;

  // Field widths
  localparam int unsigned YearW    = 14;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned HourW    = 5;
  localparam int unsigned MinuteW  = 6;
  localparam int unsigned WeekdayW = 3;
  localparam int unsigned ElapsedW = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 14;

  // Arithmetic widths
  localparam int unsigned TotalW   = ElapsedW + 1;   // remainder plus elapsed
  localparam int unsigned RemW     = 16;             // ms below one minute
  localparam int unsigned QuotW    = 17;             // whole minutes in one item
  localparam int unsigned TmW      = 17;             // minute-of-day accumulator
  localparam int unsigned Mod400W  = 9;
  localparam int unsigned DivCntW  = 2;

  // Reciprocal division: 60000 = 1875 << 5, 400 = 25 << 4
  localparam int unsigned DivShW   = 5;
  localparam int unsigned T5W      = TotalW - DivShW;
  localparam int unsigned RecipW   = 29;
  localparam int unsigned ProdW    = T5W + RecipW;
  localparam int unsigned RecipSh  = 39;
  localparam int unsigned OddW     = 11;
  localparam int unsigned YrLoW    = 4;
  localparam int unsigned YrHiW    = YearW - YrLoW;
  localparam int unsigned YRecipW  = 11;
  localparam int unsigned YProdW   = YrHiW + YRecipW;
  localparam int unsigned YRecipSh = 15;
  localparam int unsigned Q25W     = 6;

  localparam logic [RecipW-1:0]    MsRecip       = 29'd293203101;  // ceil(2^39 / 1875)
  localparam logic [OddW-1:0]      MsOdd         = 11'd1875;
  localparam logic [YRecipW-1:0]   YearRecip     = 11'd1311;       // ceil(2^15 / 25)
  localparam logic [YrHiW-1:0]     YearOdd       = 10'd25;
  localparam logic [TmW-1:0]       MinPerDay     = 17'd1440;
  localparam logic [TmW-1:0]       MinPerHour    = 17'd60;
  localparam logic [YearW-1:0]     YearMax       = 14'd9999;
  localparam logic [Mod400W-1:0]   YearMaxMod400 = 9'd399;
  localparam logic [DivCntW-1:0]   DivStepMul    = 2'd0;
  localparam logic [DivCntW-1:0]   DivStepQuot   = 2'd1;
  localparam logic [DivCntW-1:0]   DivLastCnt    = 2'd2;
  localparam logic [WeekdayW-1:0]  WeekdayUnknown = 3'd7;
  localparam logic [WeekdayW-1:0]  WeekdaySunday  = 3'd6;
  localparam logic [MonthW:0]      LastMonth      = 5'd12;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_BASE_YEAR    = 3'd0,
    REG_BASE_MONTH   = 3'd1,
    REG_BASE_DAY     = 3'd2,
    REG_BASE_HOUR    = 3'd3,
    REG_BASE_MINUTE  = 3'd4,
    REG_BASE_WEEKDAY = 3'd5,
    REG_DATE_VALID   = 3'd6,
    REG_CONFIGURED   = 3'd7
  } cca_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SUM,
    ST_DAYS,
    ST_HOURS,
    ST_WRITE
  } cca_state_e;

  typedef struct packed {
    logic start;      // take the item, reload base on restart
    logic div_step;   // one stage of ms / 60000 and of year mod 400
    logic sum;        // form minute-of-day total
    logic day_step;   // take off one day, step the date
    logic hour_step;  // take off one hour
    logic min_set;    // leftover is the minute
    logic load_out;   // fill the output register
  } cca_cmd_t;

  typedef struct packed {
    logic configured;
    logic div_last;
    logic tm_ge_day;
    logic tm_ge_hour;
    logic out_full;
  } cca_status_t;

  // Days in a month; month 0 and months above 12 count as 31 days
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (month) inside
      4'd2:                     len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- sv/cca_in_if.sv -----
// Query channel of the calendar clock advance block.
// Carries valid, ready and the query payload. Depends on cca_pkg.
`default_nettype none

interface cca_in_if;
  logic                              valid;
  logic                              ready;
  logic                              restart;
  logic [cca_pkg::ElapsedW-1:0]      elapsed_ms;

  modport source (output valid, restart, elapsed_ms, input ready);
  modport sink   (input valid, restart, elapsed_ms, output ready);
endinterface

`default_nettype wire

// ----- sv/cca_out_if.sv -----
// Result channel of the calendar clock advance block.
// Carries valid, ready and the calendar payload. Depends on cca_pkg.
`default_nettype none

interface cca_out_if;
  logic                              valid;
  logic                              ready;
  logic [cca_pkg::YearW-1:0]         year;
  logic [cca_pkg::MonthW-1:0]        month;
  logic [cca_pkg::DayW-1:0]          day;
  logic [cca_pkg::HourW-1:0]         hour;
  logic [cca_pkg::MinuteW-1:0]       minute;
  logic [cca_pkg::WeekdayW-1:0]      weekday;
  logic                              is_configured;

  modport source (output valid, year, month, day, hour, minute, weekday, is_configured,
                  input ready);
  modport sink   (input valid, year, month, day, hour, minute, weekday, is_configured,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/calendar_clock_advance.sv -----
// Calendar clock advance: a Gregorian calendar clock that firmware queries.
// Each query item brings the milliseconds since the previous one (or a restart
// that reloads the set-up date and time first) and returns the current year,
// month, day, hour, minute and weekday. One item at a time is worked on: a
// configured query goes through accept, three stages of the reciprocal
// minute division, the minute-of-day sum, the day walk over each whole day,
// the hour walk over each hour of the day and the output write; an
// unconfigured query goes from accept straight to the output write. A
// finished result waits in an output register while the next item is taken;
// the next write waits while that result is still unread. Configuration is
// to be written only while no item is in flight; the block itself does not
// enforce it.
`default_nettype none

module calendar_clock_advance (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [cca_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [cca_pkg::CfgDataW-1:0]  cfg_data_i,
  cca_in_if.sink                             in_ch,
  cca_out_if.source                          out_ch
);

  cca_pkg::cca_cmd_t    cmd;
  cca_pkg::cca_status_t status;

  cca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cca_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .restart_i       (in_ch.restart),
    .elapsed_ms_i    (in_ch.elapsed_ms),
    .out_valid_o     (out_ch.valid),
    .out_ready_i     (out_ch.ready),
    .year_o          (out_ch.year),
    .month_o         (out_ch.month),
    .day_o           (out_ch.day),
    .hour_o          (out_ch.hour),
    .minute_o        (out_ch.minute),
    .weekday_o       (out_ch.weekday),
    .is_configured_o (out_ch.is_configured),
    .cmd_i           (cmd),
    .status_o        (status)
  );

endmodule

`default_nettype wire

// ----- sv/cca_ctrl.sv -----
// Controller of the calendar clock advance block.
// Sequences divide, sum, day walk, hour walk and output write. Depends on cca_pkg.
`default_nettype none

module cca_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire cca_pkg::cca_status_t status_i,
  output cca_pkg::cca_cmd_t         cmd_o
);

  cca_pkg::cca_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cca_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      cca_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = status_i.configured ? cca_pkg::ST_DIV : cca_pkg::ST_WRITE;
        end
      end
      cca_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = cca_pkg::ST_SUM;
        end
      end
      cca_pkg::ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = cca_pkg::ST_DAYS;
      end
      cca_pkg::ST_DAYS: begin
        if (status_i.tm_ge_day) begin
          cmd_o.day_step = 1'b1;
        end else begin
          state_d = cca_pkg::ST_HOURS;
        end
      end
      cca_pkg::ST_HOURS: begin
        if (status_i.tm_ge_hour) begin
          cmd_o.hour_step = 1'b1;
        end else begin
          cmd_o.min_set = 1'b1;
          state_d       = cca_pkg::ST_WRITE;
        end
      end
      cca_pkg::ST_WRITE: begin
        if (!status_i.out_full) begin
          cmd_o.load_out = 1'b1;
          state_d        = cca_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cca_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/cca_dp.sv -----
// Datapath of the calendar clock advance block: configuration registers,
// running calendar, reciprocal minute divider, day stepper and output register.
// Depends on cca_pkg.
`default_nettype none

module cca_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [cca_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [cca_pkg::CfgDataW-1:0]  cfg_data_i,
  // query payload
  input  wire logic                          restart_i,
  input  wire logic [cca_pkg::ElapsedW-1:0]  elapsed_ms_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [cca_pkg::YearW-1:0]          year_o,
  output logic [cca_pkg::MonthW-1:0]         month_o,
  output logic [cca_pkg::DayW-1:0]           day_o,
  output logic [cca_pkg::HourW-1:0]          hour_o,
  output logic [cca_pkg::MinuteW-1:0]        minute_o,
  output logic [cca_pkg::WeekdayW-1:0]       weekday_o,
  output logic                               is_configured_o,
  // controller
  input  wire cca_pkg::cca_cmd_t             cmd_i,
  output cca_pkg::cca_status_t               status_o
);

  // Configuration registers
  logic [cca_pkg::YearW-1:0]    base_year_q;
  logic [cca_pkg::MonthW-1:0]   base_month_q;
  logic [cca_pkg::DayW-1:0]     base_day_q;
  logic [cca_pkg::HourW-1:0]    base_hour_q;
  logic [cca_pkg::MinuteW-1:0]  base_minute_q;
  logic [cca_pkg::WeekdayW-1:0] base_weekday_q;
  logic                         date_valid_q;
  logic                         configured_q;

  // Running calendar
  logic [cca_pkg::RemW-1:0]     rem_q;
  logic [cca_pkg::YearW-1:0]    cur_year_q;
  logic [cca_pkg::MonthW-1:0]   cur_month_q;
  logic [cca_pkg::DayW-1:0]     cur_day_q;
  logic [cca_pkg::HourW-1:0]    cur_hour_q;
  logic [cca_pkg::MinuteW-1:0]  cur_minute_q;
  logic [cca_pkg::WeekdayW-1:0] cur_weekday_q;

  // Work registers
  logic [cca_pkg::TotalW-1:0]   div_q;
  logic [cca_pkg::ProdW-1:0]    prod_q;
  logic [cca_pkg::QuotW-1:0]    quot_q;
  logic [cca_pkg::RemW-1:0]     divr_q;
  logic [cca_pkg::DivCntW-1:0]  cnt_q;
  logic [cca_pkg::YearW-1:0]    yr_q;
  logic [cca_pkg::YProdW-1:0]   yprod_q;
  logic [cca_pkg::Q25W-1:0]     q25_q;
  logic [cca_pkg::Mod400W-1:0]  m400_q;
  logic [cca_pkg::TmW-1:0]      tm_q;

  // Output register
  logic                         out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_year_q    <= '0;
      base_month_q   <= 4'd1;
      base_day_q     <= 5'd1;
      base_hour_q    <= '0;
      base_minute_q  <= '0;
      base_weekday_q <= cca_pkg::WeekdayUnknown;
      date_valid_q   <= 1'b0;
      configured_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cca_pkg::cca_reg_e'(cfg_idx_i))
        cca_pkg::REG_BASE_YEAR:    base_year_q    <= cfg_data_i[cca_pkg::YearW-1:0];
        cca_pkg::REG_BASE_MONTH:   base_month_q   <= cfg_data_i[cca_pkg::MonthW-1:0];
        cca_pkg::REG_BASE_DAY:     base_day_q     <= cfg_data_i[cca_pkg::DayW-1:0];
        cca_pkg::REG_BASE_HOUR:    base_hour_q    <= cfg_data_i[cca_pkg::HourW-1:0];
        cca_pkg::REG_BASE_MINUTE:  base_minute_q  <= cfg_data_i[cca_pkg::MinuteW-1:0];
        cca_pkg::REG_BASE_WEEKDAY: base_weekday_q <= cfg_data_i[cca_pkg::WeekdayW-1:0];
        cca_pkg::REG_DATE_VALID:   date_valid_q   <= cfg_data_i[0];
        cca_pkg::REG_CONFIGURED:   configured_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Minute division: drop the five low bits, multiply by the reciprocal of 1875
  logic [cca_pkg::T5W-1:0]      t5;
  logic [cca_pkg::T5W-1:0]      rem_hi;
  assign t5     = div_q[cca_pkg::TotalW-1:cca_pkg::DivShW];
  assign rem_hi = t5 - cca_pkg::T5W'(quot_q) * cca_pkg::T5W'(cca_pkg::MsOdd);

  // Year mod 400: drop the four low bits, multiply by the reciprocal of 25
  logic [cca_pkg::YrHiW-1:0]    yr_hi;
  logic [cca_pkg::YrHiW-1:0]    r25;
  logic [cca_pkg::Mod400W-1:0]  m400_div;
  assign yr_hi    = yr_q[cca_pkg::YearW-1:cca_pkg::YrLoW];
  assign r25      = yr_hi - cca_pkg::YrHiW'(q25_q) * cca_pkg::YearOdd;
  assign m400_div = {r25[cca_pkg::Mod400W-cca_pkg::YrLoW-1:0], yr_q[cca_pkg::YrLoW-1:0]};

  // Item start values
  logic [cca_pkg::RemW-1:0]     rem_eff;
  logic [cca_pkg::TotalW-1:0]   total;
  assign rem_eff = restart_i ? '0 : rem_q;
  assign total   = {{(cca_pkg::TotalW-cca_pkg::RemW){1'b0}}, rem_eff}
                 + {1'b0, elapsed_ms_i};

  // Minute-of-day total
  logic [cca_pkg::TmW-1:0]      tm_sum;
  assign tm_sum = cca_pkg::TmW'(cur_hour_q) * cca_pkg::MinPerHour
                + cca_pkg::TmW'(cur_minute_q)
                + quot_q;

  // Day step
  logic                         leap;
  logic                         cent;
  logic [cca_pkg::DayW-1:0]     day_inc;
  logic                         month_end;
  logic [cca_pkg::MonthW:0]     month_inc;
  logic                         year_sat;

  assign cent      = (m400_q == 9'd0) || (m400_q == 9'd100)
                  || (m400_q == 9'd200) || (m400_q == 9'd300);
  assign leap      = ((cur_year_q[1:0] == 2'd0) && !cent) || (m400_q == 9'd0);
  assign day_inc   = cur_day_q + 5'd1;
  assign month_end = (day_inc == '0)
                  || (day_inc > cca_pkg::month_len(cur_month_q, leap));
  assign month_inc = {1'b0, cur_month_q} + 5'd1;
  assign year_sat  = (cur_year_q >= cca_pkg::YearMax);

  // Running calendar and work registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q         <= '0;
      cur_year_q    <= '0;
      cur_month_q   <= 4'd1;
      cur_day_q     <= 5'd1;
      cur_hour_q    <= '0;
      cur_minute_q  <= '0;
      cur_weekday_q <= cca_pkg::WeekdayUnknown;
      cnt_q         <= '0;
      m400_q        <= '0;
    end else begin
      if (cmd_i.start) begin
        // reload base on restart
        if (restart_i) begin
          rem_q         <= '0;
          cur_year_q    <= base_year_q;
          cur_month_q   <= base_month_q;
          cur_day_q     <= base_day_q;
          cur_hour_q    <= base_hour_q;
          cur_minute_q  <= base_minute_q;
          cur_weekday_q <= base_weekday_q;
        end
        cnt_q  <= '0;
        m400_q <= '0;
      end
      if (cmd_i.div_step) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == cca_pkg::DivLastCnt) begin
          m400_q <= m400_div;
        end
      end
      if (cmd_i.sum) begin
        rem_q      <= divr_q;
        cur_hour_q <= '0;
      end
      if (cmd_i.day_step && date_valid_q) begin
        if (month_end) begin
          cur_day_q <= 5'd1;
          if (month_inc > cca_pkg::LastMonth) begin
            cur_month_q <= 4'd1;
            if (year_sat) begin
              cur_year_q <= cca_pkg::YearMax;
              m400_q     <= cca_pkg::YearMaxMod400;
            end else begin
              cur_year_q <= cur_year_q + 14'd1;
              m400_q     <= (m400_q == cca_pkg::YearMaxMod400) ? '0 : m400_q + 9'd1;
            end
          end else begin
            cur_month_q <= month_inc[cca_pkg::MonthW-1:0];
          end
        end else begin
          cur_day_q <= day_inc;
        end
        // rotate a known weekday
        if (cur_weekday_q != cca_pkg::WeekdayUnknown) begin
          cur_weekday_q <= (cur_weekday_q == cca_pkg::WeekdaySunday) ? '0
                                                                     : cur_weekday_q + 3'd1;
        end
      end
      if (cmd_i.hour_step) begin
        cur_hour_q <= cur_hour_q + 5'd1;
      end
      if (cmd_i.min_set) begin
        cur_minute_q <= tm_q[cca_pkg::MinuteW-1:0];
      end
    end
  end

  // Payload work registers: multiply, take quotient, form remainder, year mod 400, minute-of-day walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      div_q <= total;
      yr_q  <= restart_i ? base_year_q : cur_year_q;
    end
    if (cmd_i.div_step) begin
      if (cnt_q == cca_pkg::DivStepMul) begin
        prod_q  <= cca_pkg::ProdW'(t5) * cca_pkg::ProdW'(cca_pkg::MsRecip);
        yprod_q <= cca_pkg::YProdW'(yr_hi) * cca_pkg::YProdW'(cca_pkg::YearRecip);
      end
      if (cnt_q == cca_pkg::DivStepQuot) begin
        quot_q <= prod_q[cca_pkg::RecipSh +: cca_pkg::QuotW];
        q25_q  <= yprod_q[cca_pkg::YRecipSh +: cca_pkg::Q25W];
      end
      if (cnt_q == cca_pkg::DivLastCnt) begin
        divr_q <= {rem_hi[cca_pkg::OddW-1:0], div_q[cca_pkg::DivShW-1:0]};
      end
    end
    if (cmd_i.sum) begin
      tm_q <= tm_sum;
    end else if (cmd_i.day_step) begin
      tm_q <= tm_q - cca_pkg::MinPerDay;
    end else if (cmd_i.hour_step) begin
      tm_q <= tm_q - cca_pkg::MinPerHour;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      is_configured_o <= configured_q;
      if (configured_q) begin
        year_o    <= cur_year_q;
        month_o   <= cur_month_q;
        day_o     <= cur_day_q;
        hour_o    <= cur_hour_q;
        minute_o  <= cur_minute_q;
        weekday_o <= cur_weekday_q;
      end else begin
        year_o    <= base_year_q;
        month_o   <= base_month_q;
        day_o     <= base_day_q;
        hour_o    <= base_hour_q;
        minute_o  <= base_minute_q;
        weekday_o <= base_weekday_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // Status to the controller
  assign status_o.configured = configured_q;
  assign status_o.div_last   = (cnt_q == cca_pkg::DivLastCnt);
  assign status_o.tm_ge_day  = (tm_q >= cca_pkg::MinPerDay);
  assign status_o.tm_ge_hour = (tm_q >= cca_pkg::MinPerHour);
  assign status_o.out_full   = out_valid_q && !out_ready_i;

endmodule

`default_nettype wire
